// File: rtl/ngga_pkg.sv
// Shared types, constants and lookup functions of the GGA position parser.
package ngga_pkg;

	localparam int DEF_FRAC_DIGITS = 5;

	// Widths fixed by the field formats.
	localparam int BYTE_W     = 8;
	localparam int INT_W      = 17;
	localparam int FRAC_MAX_W = 24;
	localparam int FCNT_W     = 3;
	localparam int DEG_W      = 10;
	localparam int MIN_W      = 7;
	localparam int NUM_W      = 30;
	localparam int QUO_W      = 24;
	localparam int POS_W      = 34;
	localparam int OUT_TDATA_W = 72;

	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	localparam logic [2:0]       PREFIX_LEN = 3'd7;
	localparam logic [INT_W-1:0] INT_SAT    = 17'd99999;

	// floor(x / 100) = (x * DIV100_M) >> DIV100_SH for any 17-bit x.
	localparam logic [17:0] DIV100_M  = 18'd167773;
	localparam int          DIV100_SH = 24;
	// floor(y / 15) = (y * DIV15_M) >> DIV15_SH for any 28-bit y.
	localparam logic [28:0] DIV15_M   = 29'd286331154;
	localparam int          DIV15_SH  = 32;

	localparam logic [POS_W-1:0] E7 = 34'd10000000;

	typedef enum logic [2:0] {
		JOB_HOLD,
		JOB_EMIT_ZERO,
		JOB_EMIT_LAT,
		JOB_EMIT_HELD,
		JOB_EMIT_LON
	} job_kind_t;

	typedef struct packed {
		job_kind_t              kind;
		logic [INT_W-1:0]       int_acc;
		logic [FRAC_MAX_W-1:0]  frac_acc;
		logic [FCNT_W-1:0]      frac_cnt;
	} ngga_job_t;

	function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] pos);
		logic [BYTE_W-1:0] ch;
		case (pos)
			3'd0: ch = 8'h24; // $
			3'd1: ch = 8'h47; // G
			3'd2: ch = 8'h50; // P
			3'd3: ch = 8'h47; // G
			3'd4: ch = 8'h47; // G
			3'd5: ch = 8'h41; // A
			3'd6: ch = 8'h2C; // ,
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [23:0] pow10(input logic [2:0] n);
		logic [23:0] p;
		case (n)
			3'd0: p = 24'd1;
			3'd1: p = 24'd10;
			3'd2: p = 24'd100;
			3'd3: p = 24'd1000;
			3'd4: p = 24'd10000;
			3'd5: p = 24'd100000;
			3'd6: p = 24'd1000000;
			default: p = 24'd10000000;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/ngga_parser.sv
// Per-byte sentence parser: prefix match, comma count and field accumulation.
module ngga_parser
	import ngga_pkg::*;
#(
	parameter int FRAC_DIGITS = DEF_FRAC_DIGITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic [BYTE_W-1:0] byte_data,
	output logic              job_valid,
	output ngga_job_t         job
);

	localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS);
	localparam int FT_W   = FRAC_W + 4;
	localparam int IT_W   = INT_W + 4;
	localparam logic [FCNT_W-1:0] FRAC_LIM = FCNT_W'(FRAC_DIGITS);

	logic [2:0]        pos_q, pos_d;
	logic              match_q, match_d;
	logic [2:0]        cc_q, cc_d;
	logic              infrac_q, infrac_d;
	logic              stop_q, stop_d;
	logic [INT_W-1:0]  int_q, int_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic [FCNT_W-1:0] fcnt_q, fcnt_d;

	logic              is_digit;
	logic [3:0]        digit;
	logic [IT_W-1:0]   int_next;
	logic [FT_W-1:0]   frac_next;
	logic [2:0]        cc_inc;
	logic              clear_field;

	always_comb begin
		is_digit  = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
		digit     = 4'(byte_data - CH_ZERO);
		int_next  = IT_W'(int_q) * IT_W'(10) + IT_W'(digit);
		frac_next = FT_W'(frac_q) * FT_W'(10) + FT_W'(digit);
		cc_inc    = (cc_q < 3'd5) ? cc_q + 3'd1 : cc_q;

		pos_d       = pos_q;
		match_d     = match_q;
		cc_d        = cc_q;
		infrac_d    = infrac_q;
		stop_d      = stop_q;
		int_d       = int_q;
		frac_d      = frac_q;
		fcnt_d      = fcnt_q;
		clear_field = 1'b0;

		job_valid     = 1'b0;
		job.kind      = JOB_HOLD;
		job.int_acc   = int_q;
		job.frac_acc  = FRAC_MAX_W'(frac_q);
		job.frac_cnt  = fcnt_q;

		if (byte_data == CH_LF) begin
			if (match_q && (pos_q == PREFIX_LEN)) begin
				job_valid = 1'b1;
				case (cc_q)
					3'd2:    job.kind = JOB_EMIT_LAT;
					3'd3:    job.kind = JOB_EMIT_HELD;
					3'd4,
					3'd5:    job.kind = JOB_EMIT_LON;
					default: job.kind = JOB_EMIT_ZERO;
				endcase
			end
			pos_d       = 3'd0;
			match_d     = 1'b1;
			cc_d        = 3'd0;
			clear_field = 1'b1;
		end else if (match_q) begin
			if (pos_q != PREFIX_LEN) begin
				if (byte_data == prefix_char(pos_q)) begin
					pos_d = pos_q + 3'd1;
					if (pos_d == PREFIX_LEN) begin
						cc_d = 3'd1;
					end
				end else begin
					match_d = 1'b0;
				end
			end else if (byte_data == CH_COMMA) begin
				cc_d = cc_inc;
				case (cc_inc)
					3'd2: clear_field = 1'b1;
					3'd3: begin
						// The latitude field closes: convert it now and keep it.
						job_valid   = 1'b1;
						job.kind    = JOB_HOLD;
						clear_field = 1'b1;
					end
					3'd4: clear_field = 1'b1;
					default: stop_d = 1'b1;
				endcase
			end else if (((cc_q == 3'd2) || (cc_q == 3'd4)) && !stop_q) begin
				if (is_digit) begin
					if (infrac_q) begin
						if (fcnt_q < FRAC_LIM) begin
							frac_d = FRAC_W'(frac_next);
							fcnt_d = fcnt_q + 3'd1;
						end
					end else begin
						int_d = (int_next > IT_W'(INT_SAT)) ? INT_SAT : INT_W'(int_next);
					end
				end else if ((byte_data == CH_POINT) && !infrac_q) begin
					infrac_d = 1'b1;
				end else begin
					stop_d = 1'b1;
				end
			end
		end

		if (clear_field) begin
			infrac_d = 1'b0;
			stop_d   = 1'b0;
			int_d    = '0;
			frac_d   = '0;
			fcnt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			match_q  <= 1'b1;
			cc_q     <= '0;
			infrac_q <= 1'b0;
			stop_q   <= 1'b0;
			int_q    <= '0;
			frac_q   <= '0;
			fcnt_q   <= '0;
		end else if (byte_valid) begin
			pos_q    <= pos_d;
			match_q  <= match_d;
			cc_q     <= cc_d;
			infrac_q <= infrac_d;
			stop_q   <= stop_d;
			int_q    <= int_d;
			frac_q   <= frac_d;
			fcnt_q   <= fcnt_d;
		end
	end

endmodule

// File: rtl/ngga_convert.sv
// Pipelined conversion of a ddmm.mmmmm field to degrees times 10^7.
module ngga_convert
	import ngga_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             job_valid,
	input  ngga_job_t        job,
	output logic             res_valid,
	output job_kind_t        res_kind,
	output logic [POS_W-1:0] res_value
);

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	job_kind_t             kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	logic [INT_W-1:0]      int_s1, int_s2;
	logic [FRAC_MAX_W-1:0] frac_s1, frac_s2, frac_s3;
	logic [FCNT_W-1:0]     fc_s1, fc_s2, fc_s3, fc_s4;
	logic [DEG_W-1:0]      deg_s2;
	logic [MIN_W-1:0]      m_s3;
	logic [POS_W-1:0]      dege7_s3, dege7_s4, dege7_s5, dege7_s6;
	logic [NUM_W-1:0]      n_s4, x_s5;
	logic [QUO_W-1:0]      q_s6;

	logic [34:0]           deg_prod;
	logic [INT_W-1:0]      m_wide;
	logic [NUM_W-1:0]      n_next;
	logic [53:0]           x_prod;
	logic [56:0]           q_prod;

	always_comb begin
		deg_prod = 35'(int_s1) * 35'(DIV100_M);
		m_wide   = int_s2 - INT_W'(deg_s2) * INT_W'(100);
		n_next   = NUM_W'(m_s3) * NUM_W'(pow10(fc_s3)) + NUM_W'(frac_s3);
		// Scaling by 10^(7 - fc) turns minutes/60 * 10^7 into one divide by 60.
		x_prod   = 54'(n_s4) * 54'(pow10(3'd7 - fc_s4));
		// x / 60 is (x / 4) / 15.
		q_prod   = 57'(x_s5[NUM_W-1:2]) * 57'(DIV15_M);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (advance) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1  <= job.kind;
			int_s1   <= job.int_acc;
			frac_s1  <= job.frac_acc;
			fc_s1    <= job.frac_cnt;

			kind_s2  <= kind_s1;
			int_s2   <= int_s1;
			frac_s2  <= frac_s1;
			fc_s2    <= fc_s1;
			deg_s2   <= DEG_W'(deg_prod >> DIV100_SH);

			kind_s3  <= kind_s2;
			frac_s3  <= frac_s2;
			fc_s3    <= fc_s2;
			m_s3     <= MIN_W'(m_wide);
			dege7_s3 <= POS_W'(deg_s2) * E7;

			kind_s4  <= kind_s3;
			fc_s4    <= fc_s3;
			dege7_s4 <= dege7_s3;
			n_s4     <= n_next;

			kind_s5  <= kind_s4;
			dege7_s5 <= dege7_s4;
			x_s5     <= NUM_W'(x_prod);

			kind_s6  <= kind_s5;
			dege7_s6 <= dege7_s5;
			q_s6     <= QUO_W'(q_prod >> DIV15_SH);
		end
	end

	assign res_valid = v_s6;
	assign res_kind  = kind_s6;
	assign res_value = dege7_s6 + POS_W'(q_s6);

	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> deg_s2 <= DEG_W'(999))
		else $error("degree quotient out of range");

	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> m_s3 < MIN_W'(100))
		else $error("minute remainder out of range");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> q_s6 < QUO_W'(16666667))
		else $error("minute quotient out of range");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance && v_s5 |=> v_s6)
		else $error("job lost between stages");

endmodule

// File: rtl/nmea_gga_position_parser_core.sv
// Top level: GGA sentence parser with a conversion pipeline and result register.
// Throughput: one byte per cycle whenever the result register is free or being taken.
// A result beat reaches m_tvalid after its newline beat is accepted, passing the job register,
// the five conversion stages behind it and then the result register.
// A held result stalls the whole pipeline and drops s_tready until it is taken.
// Reset (arst_n low, asynchronous) returns the parser to the start of a line and
// empties the pipeline and result register; no clearing pass is needed.
module nmea_gga_position_parser_core
	import ngga_pkg::*;
#(
	parameter int FRAC_DIGITS = DEF_FRAC_DIGITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // [33:0] latitude_e7, [67:34] longitude_e7
);

	logic             advance;
	logic             accept;
	logic             job_valid;
	ngga_job_t        job;
	logic             res_valid;
	job_kind_t        res_kind;
	logic [POS_W-1:0] res_value;
	logic [POS_W-1:0] lat_held_q;
	logic             m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	assign advance  = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && advance;
	assign s_tready = advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ngga_parser #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(accept),
		.byte_data (s_tdata),
		.job_valid (job_valid),
		.job       (job)
	);

	ngga_convert u_convert (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.job_valid(accept && job_valid),
		.job      (job),
		.res_valid(res_valid),
		.res_kind (res_kind),
		.res_value(res_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= res_valid && (res_kind != JOB_HOLD);
		end
	end

	// When a line's latitude field has closed, that latitude is converted ahead of the line's newline job,
	// so it is in place by the time the newline job reaches this stage.
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			case (res_kind)
				JOB_HOLD: lat_held_q <= res_value;
				JOB_EMIT_LAT: m_tdata_q <= {4'b0, {POS_W{1'b0}}, res_value};
				JOB_EMIT_HELD: m_tdata_q <= {4'b0, {POS_W{1'b0}}, lat_held_q};
				JOB_EMIT_LON: m_tdata_q <= {4'b0, res_value, lat_held_q};
				JOB_EMIT_ZERO: m_tdata_q <= '0;
				default: m_tdata_q <= '0;
			endcase
		end
	end

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while a result beat is stalled");

	a_hold_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid && res_kind == JOB_HOLD |=> !m_tvalid)
		else $error("held latitude produced an output beat");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_value <= POS_W'(64'd10006666666))
		else $error("converted position out of range");

endmodule
